FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: rtl/core/dkmpq_pkg.sv
package dkmpq_pkg;
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_LOWERED  = 3'd1;
	localparam logic [2:0] ST_IGNORED  = 3'd2;
	localparam logic [2:0] ST_POPPED   = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	// Controller to datapath.
	typedef struct packed {
		logic load;   // capture incoming beat, start scan at slot 0
		logic scan;   // examine one slot, advance index
		logic commit; // apply the scan result to the slot store and result registers
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_last; // current slot is the last one
		logic hit;       // update: key found early, scan may stop
	} dp_stat_t;
endpackage

FILE: rtl/core/dkmpq_ctrl.sv
module dkmpq_ctrl
	import dkmpq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;

	// Accept while idle; the result register frees as soon as the beat leaves.
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid && !in_stall;
		cmd.scan   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_DONE) && !(out_valid_q && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_SCAN;
				// Stop on a key hit; after the last read, wait for its compare.
				S_SCAN: begin
					if (stat.hit)
						state_q <= S_DONE;
					else if (stat.scan_last)
						state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_DONE;
				S_DONE: if (cmd.commit) state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/dkmpq_dp.sv
module dkmpq_dp
	import dkmpq_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int KEY_BITS    = 32,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  logic                   in_command,
	input  logic [KEY_BITS-1:0]    in_key,
	input  logic [WEIGHT_BITS-1:0] in_weight,
	output logic [2:0]             status,
	output logic [31:0]            popped_key,
	output logic [31:0]            popped_weight,
	output logic [6:0]             occupancy
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_BITS-1:0]    slot_key_q    [CAPACITY];
	logic [WEIGHT_BITS-1:0] slot_weight_q [CAPACITY];
	logic [CAPACITY-1:0]    slot_valid_q;
	logic [CW-1:0]          count_q;

	logic                   cmd_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic [IW-1:0]          idx_q;
	logic                   found_q;   // key match or pop candidate held
	logic [IW-1:0]          found_idx_q;
	logic [KEY_BITS-1:0]    best_key_q;
	logic [WEIGHT_BITS-1:0] best_w_q;
	logic                   free_ok_q;
	logic [IW-1:0]          free_idx_q;

	logic [2:0]             status_q;
	logic [KEY_BITS-1:0]    pk_q;
	logic [WEIGHT_BITS-1:0] pw_q;
	logic [CW-1:0]          occ_q;

	// Registered slot read, compared in the cycle after the read is issued.
	logic                   scan_s1;
	logic [IW-1:0]          idx_s1;
	logic                   rd_v_s1;
	logic [KEY_BITS-1:0]    rd_k_s1;
	logic [WEIGHT_BITS-1:0] rd_w_s1;
	logic                   cmp_en;
	logic                   match;
	logic                   better;

	// Drop compares that trail a key hit.
	assign cmp_en = scan_s1 && !(cmd_q == CMD_UPDATE && found_q);
	assign match  = rd_v_s1 && (rd_k_s1 == key_q);
	assign better = rd_v_s1 && (!found_q || rd_w_s1 < best_w_q ||
		(rd_w_s1 == best_w_q && rd_k_s1 < best_key_q));

	assign stat.scan_last = (idx_q == IW'(CAPACITY - 1));
	assign stat.hit       = cmp_en && (cmd_q == CMD_UPDATE) && match;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= in_command;
			key_q    <= in_key;
			weight_q <= in_weight;
		end
		if (cmd.scan) begin
			rd_k_s1 <= slot_key_q[idx_q];
			rd_w_s1 <= slot_weight_q[idx_q];
			rd_v_s1 <= slot_valid_q[idx_q];
			idx_s1  <= idx_q;
		end
		if (cmp_en && cmd_q == CMD_POP && better) begin
			best_key_q <= rd_k_s1;
			best_w_q   <= rd_w_s1;
		end
		if (cmp_en && cmd_q == CMD_UPDATE && match)
			best_w_q <= rd_w_s1;
		if (cmp_en && !rd_v_s1 && !free_ok_q)
			free_idx_q <= idx_s1;
		if (cmp_en && ((cmd_q == CMD_POP && better) ||
				(cmd_q == CMD_UPDATE && match)))
			found_idx_q <= idx_s1;
		if (cmd.commit) begin
			if (cmd_q == CMD_POP) begin
				if (found_q) begin
					status_q <= ST_POPPED;
					pk_q     <= best_key_q;
					pw_q     <= best_w_q;
				end else begin
					status_q <= ST_EMPTY;
					pk_q     <= '0;
					pw_q     <= '0;
				end
			end else begin
				pk_q <= '0;
				pw_q <= '0;
				if (found_q) begin
					if (weight_q < best_w_q) begin
						status_q <= ST_LOWERED;
						slot_weight_q[found_idx_q] <= weight_q;
					end else begin
						status_q <= ST_IGNORED;
					end
				end else if (free_ok_q && count_q < CW'(CAPACITY)) begin
					status_q <= ST_INSERTED;
					slot_key_q[free_idx_q]    <= key_q;
					slot_weight_q[free_idx_q] <= weight_q;
				end else begin
					status_q <= ST_FULL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			count_q      <= '0;
			occ_q        <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_ok_q    <= 1'b0;
			scan_s1      <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q     <= '0;
				found_q   <= 1'b0;
				free_ok_q <= 1'b0;
			end
			if (cmd.scan && !stat.scan_last)
				idx_q <= idx_q + 1'b1;
			if (cmp_en) begin
				if (!rd_v_s1)
					free_ok_q <= 1'b1;
				if ((cmd_q == CMD_POP && better) || (cmd_q == CMD_UPDATE && match))
					found_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (cmd_q == CMD_POP) begin
					if (found_q) begin
						slot_valid_q[found_idx_q] <= 1'b0;
						count_q <= count_q - 1'b1;
						occ_q   <= count_q - 1'b1;
					end else begin
						occ_q <= count_q;
					end
				end else if (!found_q && free_ok_q && count_q < CW'(CAPACITY)) begin
					slot_valid_q[free_idx_q] <= 1'b1;
					count_q <= count_q + 1'b1;
					occ_q   <= count_q + 1'b1;
				end else begin
					occ_q <= count_q;
				end
			end
		end
	end

	assign status        = status_q;
	assign popped_key    = 32'(pk_q);
	assign popped_weight = 32'(pw_q);
	assign occupancy     = 7'(occ_q);
endmodule

FILE: rtl/core/decrease_key_min_priority_queue.sv
// Sequencing: each slot read is registered and compared in the next cycle;
// an update scan stops at a key hit, while a pop always scans every slot.
// One item at a time: a new beat is taken once the block is idle, which can
// be in the cycle the result appears unless out_stall holds the result.
// Reset: arst_n clears slot valid bits, entry count, occupancy, output valid,
// control state, scan index and flags; slot contents and results stay as is.
module decrease_key_min_priority_queue
	import dkmpq_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int KEY_BITS    = 32,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [WEIGHT_BITS-1:0] weight,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             status,
	output logic [31:0]            popped_key,
	output logic [31:0]            popped_weight,
	output logic [6:0]             occupancy
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each beat: load, scan slots, commit into the result register.
	dkmpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the slot store and compare one slot per cycle.
	dkmpq_dp #(
		.CAPACITY    (CAPACITY),
		.KEY_BITS    (KEY_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_command    (command),
		.in_key        (key),
		.in_weight     (weight),
		.status        (status),
		.popped_key    (popped_key),
		.popped_weight (popped_weight),
		.occupancy     (occupancy)
	);
endmodule

FILE: rtl/core/dkmpq_checker.sv
`include "assert_macros.svh"
module dkmpq_checker
	import dkmpq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic [6:0] occupancy
);
	`ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(status), "result beat changed while stalled")
	`ASSERT_ALWAYS(a_status_range, clk, arst_n, !out_valid || status <= ST_FULL, "status code out of range")
	`ASSERT_IMPL(a_one_result, clk, arst_n, in_valid && !in_stall |=> !out_valid || out_stall, "result appeared without its scan")
	`ASSERT_IMPL(a_empty_occ, clk, arst_n, out_valid && status == ST_EMPTY |-> occupancy == 7'd0, "pop on empty with entries held")
endmodule

bind decrease_key_min_priority_queue dkmpq_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.occupancy (occupancy)
);
